// File: hdl/xrg_pkg.sv
// Package for the xoshiro256** generator: payload structs, the constants of the
// SplitMix64 seeding and the control structs between the sequencer and the multiplier.
// No dependencies.
package xrg_pkg;

	localparam int unsigned WORD_W   = 64;
	localparam int unsigned FRAC_W   = 53;
	localparam int unsigned PADDR_W  = 4;
	localparam int unsigned PDATA_W  = 64;
	localparam int unsigned REG_IDX_W = 1;

	localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

	localparam int unsigned SHIFT_MIX_1 = 30;
	localparam int unsigned SHIFT_MIX_2 = 27;
	localparam int unsigned SHIFT_MIX_3 = 31;
	localparam int unsigned SHIFT_FRAC  = 11;
	localparam int unsigned SHIFT_T     = 17;

	// Register indexes of the configuration port.
	localparam logic [REG_IDX_W-1:0] REG_DEFAULT_SEED = 1'b0;

	typedef struct packed {
		logic              mode;
		logic [WORD_W-1:0] seed;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] random_word;
		logic [FRAC_W-1:0] unit_fraction;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_sts_t;

endpackage

// File: hdl/xrg_cfg.sv
// APB-style register file of the xoshiro256** generator: holds default_seed.
// Depends on xrg_pkg.
module xrg_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [xrg_pkg::PADDR_W-1:0]  paddr,
	input  logic [xrg_pkg::PDATA_W-1:0]  pwdata,
	output logic [xrg_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [xrg_pkg::WORD_W-1:0]   default_seed
);

	logic [xrg_pkg::REG_IDX_W-1:0] reg_idx;
	logic [xrg_pkg::WORD_W-1:0]    default_seed_q;
	logic                          wr_en;

	// Registers sit eight bytes apart.
	assign reg_idx = paddr[xrg_pkg::PADDR_W-1:3];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_seed_q <= '0;
		end else if (wr_en && reg_idx == xrg_pkg::REG_DEFAULT_SEED) begin
			default_seed_q <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == xrg_pkg::REG_DEFAULT_SEED) begin
			prdata = default_seed_q;
		end
	end

	assign default_seed = default_seed_q;

endmodule

// File: hdl/xrg_mul.sv
// Iterative 64-bit multiplier that keeps the low 64 bits of the product.
// One 32x32 multiplier, reused per partial product. Depends on xrg_pkg.
module xrg_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  xrg_pkg::mul_req_t          req,
	output xrg_pkg::mul_sts_t          sts,
	output logic [xrg_pkg::WORD_W-1:0] product
);

	logic [xrg_pkg::WORD_W-1:0] a_q;
	logic [xrg_pkg::WORD_W-1:0] b_q;
	logic [xrg_pkg::WORD_W-1:0] acc_q;
	logic [1:0]                 step_q;
	logic                       busy_q;
	logic                       done_q;
	logic [31:0]                mul_x;
	logic [31:0]                mul_y;
	logic [63:0]                mul_p;

	// Low product, then the two cross terms, which only reach the upper half.
	always_comb begin
		unique case (step_q)
			2'd0: begin
				mul_x = a_q[31:0];
				mul_y = b_q[31:0];
			end
			2'd1: begin
				mul_x = a_q[31:0];
				mul_y = b_q[63:32];
			end
			default: begin
				mul_x = a_q[63:32];
				mul_y = b_q[31:0];
			end
		endcase
	end

	assign mul_p = 64'(mul_x) * 64'(mul_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					step_q <= '0;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			if (step_q == 2'd0) begin
				acc_q <= mul_p;
			end else begin
				acc_q <= acc_q + {mul_p[31:0], 32'd0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = acc_q;

endmodule

// File: hdl/xoshiro_random_generator.sv
// Top level of the xoshiro256** generator with SplitMix64 seeding.
// Items are seeded draws, reseeds and draws that first seed themselves. Each seeding word
// goes twice through the three-pass shared 32x32 multiplier. One item is in work at a time
// and the next is taken the cycle after the result reaches the output register. Reset
// (asynchronous, active low) clears the state words, the seeded flag and default_seed.
module xoshiro_random_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  xrg_pkg::in_item_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output xrg_pkg::out_item_t           out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [xrg_pkg::PADDR_W-1:0]  paddr,
	input  logic [xrg_pkg::PDATA_W-1:0]  pwdata,
	output logic [xrg_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_ADD,
		ST_MIX_A,
		ST_WAIT_A,
		ST_MIX_B,
		ST_WAIT_B,
		ST_DRAW1,
		ST_DRAW2,
		ST_FINISH
	} state_t;

	localparam int unsigned W = xrg_pkg::WORD_W;

	state_t                state_q;
	logic [W-1:0]          gen_q [4];
	logic                  seeded_q;
	logic                  draw_q;
	logic [1:0]            idx_q;
	logic [W-1:0]          acc_q;
	logic [W-1:0]          z_q;
	logic [W-1:0]          prod_q;
	logic [W-1:0]          res_q;
	logic                  out_valid_q;
	xrg_pkg::out_item_t    out_data_q;

	logic [W-1:0]          default_seed;
	xrg_pkg::mul_req_t     mul_req;
	xrg_pkg::mul_sts_t     mul_sts;
	logic [W-1:0]          mul_p;
	logic                  in_xfer;
	logic                  out_free;
	logic [W-1:0]          mix_out;
	logic [W-1:0]          w1_x5;
	logic [W-1:0]          n0;
	logic [W-1:0]          n1;
	logic [W-1:0]          n2;
	logic [W-1:0]          n3;

	xrg_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.default_seed (default_seed)
	);

	xrg_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.sts     (mul_sts),
		.product (mul_p)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid & ~in_stall;
	assign out_free = ~(out_valid_q & out_stall);

	always_comb begin
		mul_req.start = (state_q == ST_MIX_A) || (state_q == ST_MIX_B);
		if (state_q == ST_MIX_A) begin
			mul_req.a = acc_q ^ (acc_q >> xrg_pkg::SHIFT_MIX_1);
			mul_req.b = xrg_pkg::MIX_MUL_A;
		end else begin
			mul_req.a = z_q ^ (z_q >> xrg_pkg::SHIFT_MIX_2);
			mul_req.b = xrg_pkg::MIX_MUL_B;
		end
	end

	assign mix_out = mul_p ^ (mul_p >> xrg_pkg::SHIFT_MIX_3);
	assign w1_x5   = gen_q[1] + (gen_q[1] << 2);

	// State advance of xoshiro256.
	assign n2 = gen_q[2] ^ gen_q[0];
	assign n3 = gen_q[3] ^ gen_q[1];
	assign n1 = gen_q[1] ^ n2;
	assign n0 = gen_q[0] ^ n3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			draw_q      <= 1'b0;
			idx_q       <= '0;
			acc_q       <= '0;
			z_q         <= '0;
			prod_q      <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				gen_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						idx_q <= '0;
						if (in_data.mode) begin
							acc_q   <= in_data.seed;
							draw_q  <= 1'b0;
							state_q <= ST_SEED_ADD;
						end else if (!seeded_q) begin
							acc_q   <= default_seed;
							draw_q  <= 1'b1;
							state_q <= ST_SEED_ADD;
						end else begin
							state_q <= ST_DRAW1;
						end
					end
				end
				ST_SEED_ADD: begin
					acc_q   <= acc_q + xrg_pkg::GOLDEN_STEP;
					state_q <= ST_MIX_A;
				end
				ST_MIX_A: begin
					state_q <= ST_WAIT_A;
				end
				ST_WAIT_A: begin
					if (mul_sts.done) begin
						z_q     <= mul_p;
						state_q <= ST_MIX_B;
					end
				end
				ST_MIX_B: begin
					state_q <= ST_WAIT_B;
				end
				ST_WAIT_B: begin
					if (mul_sts.done) begin
						gen_q[idx_q] <= mix_out;
						if (idx_q == 2'd3) begin
							seeded_q <= 1'b1;
							idx_q    <= '0;
							if (draw_q) begin
								state_q <= ST_DRAW1;
							end else begin
								res_q   <= '0;
								state_q <= ST_FINISH;
							end
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ST_SEED_ADD;
						end
					end
				end
				ST_DRAW1: begin
					prod_q  <= {w1_x5[W-8:0], w1_x5[W-1:W-7]};
					state_q <= ST_DRAW2;
				end
				ST_DRAW2: begin
					res_q    <= prod_q + (prod_q << 3);
					gen_q[0] <= n0;
					gen_q[1] <= n1;
					gen_q[2] <= n2 ^ (gen_q[1] << xrg_pkg::SHIFT_T);
					gen_q[3] <= {n3[W-46:0], n3[W-1:W-45]};
					state_q  <= ST_FINISH;
				end
				ST_FINISH: begin
					// The result waits here while the previous one is still held.
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_data_q.random_word   <= res_q;
			out_data_q.unit_fraction <= res_q[W-1:xrg_pkg::SHIFT_FRAC];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_sts.done |-> (state_q == ST_WAIT_A || state_q == ST_WAIT_B))
		else $error("multiplier finished outside a wait state");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q ##1 out_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("result raised without a finished item");

	a_draw_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW1 || state_q == ST_FINISH) |-> seeded_q)
		else $error("draw or result without a seeded state");

	a_no_mul_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> !mul_sts.busy)
		else $error("multiplier started while busy");
`endif

endmodule

// File: verif/tb_xoshiro_random_generator.sv
`timescale 1ns / 100ps
// Self-checking testbench for xoshiro_random_generator: a scoreboard class predicts every
// draw and reseed, plain tasks drive the input and APB ports. Depends on xrg_pkg.
module tb_xoshiro_random_generator;

	localparam logic MODE_DRAW = 1'b0;
	localparam logic MODE_SEED = 1'b1;
	localparam logic [xrg_pkg::PADDR_W-1:0] ADDR_SEED  =
		(xrg_pkg::PADDR_W)'(xrg_pkg::REG_DEFAULT_SEED) << 3;
	localparam logic [xrg_pkg::PADDR_W-1:0] ADDR_SPARE = (xrg_pkg::PADDR_W)'(8);
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic [63:0] SM_INCREMENT = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] SM_MUL_1 = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] SM_MUL_2 = 64'h94D0_49BB_1331_11EB;

	class xoshiro_scoreboard;
		logic [63:0] words [4];
		bit seeded;
		logic [63:0] default_seed;
		xrg_pkg::out_item_t expected_draws[$];
		int faults, n_draws, n_reseeds, n_self_seeded, n_checked;

		function new();
			foreach (words[i])
				words[i] = '0;
			seeded = 1'b0;
			default_seed = '0;
		endfunction

		function logic [63:0] rotl(input logic [63:0] v, input int r);
			return (v << r) | (v >> (64 - r));
		endfunction

		// Four successive SplitMix64 outputs fill the state words.
		function void load_seed(input logic [63:0] s);
			logic [63:0] acc, z;
			acc = s;
			for (int i = 0; i < 4; i++) begin
				acc = acc + SM_INCREMENT;
				z = (acc ^ (acc >> 30)) * SM_MUL_1;
				z = (z ^ (z >> 27)) * SM_MUL_2;
				words[i] = z ^ (z >> 31);
			end
			seeded = 1'b1;
		endfunction

		function void fault(input string msg);
			faults++;
			if (faults <= 10)
				$display("[%0t] %s", $realtime, msg);
		endfunction

		function void write_reg(input logic [xrg_pkg::PADDR_W-1:0] addr,
				input logic [63:0] value);
			int idx;
			idx = int'(addr >> 3);
			if (idx == int'(xrg_pkg::REG_DEFAULT_SEED))
				default_seed = value;
		endfunction

		function void check_readback(input logic [63:0] value);
			if (value !== default_seed)
				fault($sformatf("default_seed read back: expected %h, got %h",
					default_seed, value));
		endfunction

		function void take_item(input xrg_pkg::in_item_t item);
			xrg_pkg::out_item_t res;
			logic [63:0] t;
			if (item.mode == MODE_SEED) begin
				load_seed(item.seed);
				res = '0;
				n_reseeds++;
			end else begin
				if (!seeded) begin
					load_seed(default_seed);
					n_self_seeded++;
				end
				res.random_word = rotl(words[1] * 64'd5, 7) * 64'd9;
				res.unit_fraction = res.random_word[63:11];
				t = words[1] << 17;
				words[2] ^= words[0];
				words[3] ^= words[1];
				words[1] ^= words[2];
				words[0] ^= words[3];
				words[2] ^= t;
				words[3] = rotl(words[3], 45);
				n_draws++;
			end
			expected_draws.push_back(res);
		endfunction

		function void check_result(input xrg_pkg::out_item_t got);
			xrg_pkg::out_item_t exp;
			if (expected_draws.size() == 0) begin
				fault($sformatf("result %h / %h arrived with nothing expected",
					got.random_word, got.unit_fraction));
				return;
			end
			exp = expected_draws.pop_front();
			n_checked++;
			if (got.random_word !== exp.random_word)
				fault($sformatf("random_word: expected %h, got %h",
					exp.random_word, got.random_word));
			if (got.unit_fraction !== exp.unit_fraction)
				fault($sformatf("unit_fraction: expected %h, got %h",
					exp.unit_fraction, got.unit_fraction));
		endfunction

		function int pending();
			return expected_draws.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_stall;
	xrg_pkg::in_item_t in_data;
	logic out_valid, out_stall;
	xrg_pkg::out_item_t out_data;
	logic psel, penable, pwrite, pready;
	logic [xrg_pkg::PADDR_W-1:0] paddr;
	logic [xrg_pkg::PDATA_W-1:0] pwdata, prdata;

	xoshiro_random_generator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	xoshiro_scoreboard sb;
	int tx_gap_pct = 0;
	int rx_stall_pct = 0;
	bit rx_hold_req = 1'b0;
	int cycles = 0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_xoshiro_random_generator failed");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		return ($urandom_range(9) == 0) ? $urandom_range(60, 15) : $urandom_range(3, 1);
	endfunction

	function automatic xrg_pkg::in_item_t mk(input logic mode, input logic [63:0] seed);
		xrg_pkg::in_item_t item;
		item.mode = mode;
		item.seed = seed;
		return item;
	endfunction

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if ($urandom_range(99) < rx_stall_pct) begin
				out_stall <= 1'b1;
				repeat (gap_len()) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	task automatic send_item(input xrg_pkg::in_item_t item);
		in_data <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.take_item(item);
		if ($urandom_range(99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			in_data <= mk(1'($urandom_range(1)), rand64());
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every outstanding result has been transferred.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic apb_write(input logic [xrg_pkg::PADDR_W-1:0] addr,
			input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(addr, value);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read_check(input logic [xrg_pkg::PADDR_W-1:0] addr);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.check_readback(prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int n, input int tx_pct, input int rx_pct,
			input int reseed_pct);
		xrg_pkg::in_item_t item;
		int hold_at, pause_at;
		tx_gap_pct = tx_pct;
		rx_stall_pct = rx_pct;
		hold_at = $urandom_range(n - 1);
		pause_at = $urandom_range(n - 1);
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				rx_hold_req = 1'b1;
			if (i == pause_at)
				drain();
			item.mode = ($urandom_range(99) < reseed_pct) ? MODE_SEED : MODE_DRAW;
			case ($urandom_range(15))
				0: item.seed = '0;
				1: item.seed = '1;
				default: item.seed = rand64();
			endcase
			send_item(item);
		end
		drain();
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_write(ADDR_SEED, rand64());
		apb_read_check(ADDR_SEED);

		// The first draw finds the generator unseeded and must seed from the register.
		tx_gap_pct = 20;
		rx_stall_pct = 20;
		send_item(mk(MODE_DRAW, '1));
		send_item(mk(MODE_DRAW, rand64()));
		send_item(mk(MODE_SEED, '0));
		send_item(mk(MODE_DRAW, '0));
		send_item(mk(MODE_DRAW, rand64()));
		send_item(mk(MODE_SEED, '1));
		send_item(mk(MODE_DRAW, '1));
		send_item(mk(MODE_SEED, 64'h8000_0000_0000_0000));
		send_item(mk(MODE_DRAW, rand64()));
		// This seed makes the first SplitMix64 accumulator wrap to zero.
		send_item(mk(MODE_SEED, 64'h61C8_8646_80B5_83EB));
		send_item(mk(MODE_DRAW, rand64()));
		send_item(mk(MODE_SEED, rand64()));
		send_item(mk(MODE_SEED, rand64()));
		send_item(mk(MODE_DRAW, rand64()));
		send_item(mk(MODE_DRAW, rand64()));
		send_item(mk(MODE_DRAW, rand64()));
		drain();

		// A write outside the register map must leave default_seed alone.
		apb_write(ADDR_SEED, '0);
		apb_write(ADDR_SPARE, '1);
		apb_read_check(ADDR_SEED);
		run_phase(200, 0, 0, 15);

		apb_write(ADDR_SEED, '1);
		apb_read_check(ADDR_SEED);
		run_phase(250, 25, 25, 15);

		apb_write(ADDR_SEED, rand64());
		apb_read_check(ADDR_SEED);
		run_phase(250, 50, 10, 30);

		apb_write(ADDR_SEED, 64'h1);
		apb_read_check(ADDR_SEED);
		run_phase(200, 10, 60, 10);

		apb_write(ADDR_SEED, rand64());
		apb_read_check(ADDR_SEED);
		run_phase(130, 30, 30, 50);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d draws and %0d reseeds (%0d self-seeded from the register),",
			sb.n_draws, sb.n_reseeds, sb.n_self_seeded);
		$display("%0d results compared, %0d faults, under varied stalls and hold-offs.",
			sb.n_checked, sb.faults);
		if (sb.faults == 0 && sb.pending() == 0)
			$display("tb_xoshiro_random_generator passed");
		else
			$display("tb_xoshiro_random_generator failed");
		$finish;
	end

endmodule

// File: filelist.f
hdl/xrg_pkg.sv
hdl/xrg_cfg.sv
hdl/xrg_mul.sv
hdl/xoshiro_random_generator.sv
verif/tb_xoshiro_random_generator.sv
